### sv/vtic_pkg.sv
// shared types and constants for the video timer / interrupt controller
// no dependencies; imported by vtic_csr, vtic_core and the top level
package vtic_pkg;

   // request kinds carried on req_tuser
   localparam logic [2:0] REQ_TICK   = 3'd0;
   localparam logic [2:0] REQ_VBLANK = 3'd1;
   localparam logic [2:0] REQ_IACK   = 3'd2;
   localparam logic [2:0] REQ_ACK_WR = 3'd3;
   localparam logic [2:0] REQ_LOAD   = 3'd4;

   // configuration register indexes
   localparam logic [2:0] CSR_TIMER_RELOAD     = 3'd0;
   localparam logic [2:0] CSR_RELOAD_WHEN_ZERO = 3'd1;
   localparam logic [2:0] CSR_RELOAD_AT_VBLANK = 3'd2;
   localparam logic [2:0] CSR_TIMER_IRQ_ENABLE = 3'd3;
   localparam logic [2:0] CSR_ANIM_RELOAD      = 3'd4;

   // bit positions in the armed and pending flag vectors
   localparam int FLAG_VBLANK = 0;
   localparam int FLAG_TIMER  = 1;
   localparam int FLAG_RESET  = 2;

   localparam logic [2:0] ARMED_RESET_VALUE   = 3'b011;
   localparam logic [2:0] PENDING_RESET_VALUE = 3'b100;

   // interrupt levels, also the cpu acknowledge levels
   localparam logic [1:0] IRQ_NONE   = 2'd0;
   localparam logic [1:0] IRQ_VBLANK = 2'd1;
   localparam logic [1:0] IRQ_TIMER  = 2'd2;
   localparam logic [1:0] IRQ_RESET  = 2'd3;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [2:0]  iack_level;
      logic [2:0]  ack_mask;
      logic [31:0] load_value;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  irq_level;
      logic [2:0]  anim_frame;
      logic        timer_fired;
      logic [31:0] timer_count;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0] timer_reload;
      logic        reload_when_zero;
      logic        reload_at_vblank;
      logic        timer_irq_enable;
      logic [7:0]  anim_reload;
   } cfg_type;

endpackage

### sv/vtic_csr.sv
// configuration register file for the video timer / interrupt controller
// depends on vtic_pkg
module vtic_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_addr,
   input  logic [31:0]      csr_wdata,
   output vtic_pkg::cfg_type cfg
);
   import vtic_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_addr)
            CSR_TIMER_RELOAD:     cfg_in.timer_reload     = csr_wdata;
            CSR_RELOAD_WHEN_ZERO: cfg_in.reload_when_zero = csr_wdata[0];
            CSR_RELOAD_AT_VBLANK: cfg_in.reload_at_vblank = csr_wdata[0];
            CSR_TIMER_IRQ_ENABLE: cfg_in.timer_irq_enable = csr_wdata[0];
            CSR_ANIM_RELOAD:      cfg_in.anim_reload      = csr_wdata[7:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/vtic_core.sv
// event state update: timer counter, animation divider, armed and pending flags
// depends on vtic_pkg; state advances only on a step from the top level
module vtic_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  vtic_pkg::req_item_type item,
   input  vtic_pkg::cfg_type      cfg,
   output vtic_pkg::rsp_item_type result
);
   import vtic_pkg::*;

   logic [31:0] count_ff, count_in;
   logic [7:0]  div_ff, div_in;
   logic [2:0]  frame_ff, frame_in;
   logic [2:0]  armed_ff, armed_in;
   logic [2:0]  pend_ff, pend_in;
   logic        fired;
   logic [31:0] count_dec;

   assign count_dec = count_ff - 32'd1;

   always_comb begin
      count_in = count_ff;
      div_in   = div_ff;
      frame_in = frame_ff;
      armed_in = armed_ff;
      pend_in  = pend_ff;
      fired    = 1'b0;
      unique case (item.req_type)
         REQ_TICK: begin
            // a tick with the counter at zero is a no-op
            if (count_ff != '0) begin
               count_in = count_dec;
               if (count_dec == '0) begin
                  if (cfg.reload_when_zero) count_in = cfg.timer_reload;
                  if (armed_ff[FLAG_TIMER] && cfg.timer_irq_enable) begin
                     armed_in[FLAG_TIMER] = 1'b0;
                     pend_in[FLAG_TIMER]  = 1'b1;
                     fired                = 1'b1;
                  end
               end
            end
         end
         REQ_VBLANK: begin
            if (armed_ff[FLAG_VBLANK]) begin
               armed_in[FLAG_VBLANK] = 1'b0;
               pend_in[FLAG_VBLANK]  = 1'b1;
            end
            if (cfg.reload_at_vblank) count_in = cfg.timer_reload;
            if (div_ff == '0) begin
               div_in   = cfg.anim_reload;
               frame_in = frame_ff + 3'd1;
            end else begin
               div_in = div_ff - 8'd1;
            end
         end
         REQ_IACK: begin
            priority if (item.iack_level == {1'b0, IRQ_VBLANK}) pend_in[FLAG_VBLANK] = 1'b0;
            else if (item.iack_level == {1'b0, IRQ_TIMER})      pend_in[FLAG_TIMER]  = 1'b0;
            else if (item.iack_level == {1'b0, IRQ_RESET})      pend_in[FLAG_RESET]  = 1'b0;
            else                                                pend_in = pend_ff;
         end
         REQ_ACK_WR: armed_in = armed_ff | item.ack_mask;
         REQ_LOAD:   count_in = item.load_value;
         default:    count_in = count_ff;
      endcase
   end

   always_comb begin
      priority if (pend_in[FLAG_RESET])  result.irq_level = IRQ_RESET;
      else if (pend_in[FLAG_TIMER])      result.irq_level = IRQ_TIMER;
      else if (pend_in[FLAG_VBLANK])     result.irq_level = IRQ_VBLANK;
      else                               result.irq_level = IRQ_NONE;
      result.anim_frame  = frame_in;
      result.timer_fired = fired;
      result.timer_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         div_ff   <= '0;
         frame_ff <= '0;
         armed_ff <= ARMED_RESET_VALUE;
         pend_ff  <= PENDING_RESET_VALUE;
      end else if (step) begin
         count_ff <= count_in;
         div_ff   <= div_in;
         frame_ff <= frame_in;
         armed_ff <= armed_in;
         pend_ff  <= pend_in;
      end
   end

   a_fire_sets_pending: assert property (@(posedge clock) disable iff (reset)
      step && fired |=> pend_ff[FLAG_TIMER] && !armed_ff[FLAG_TIMER])
      else $error("timer fire did not set pending and disarm");

   a_frame_only_on_vblank: assert property (@(posedge clock) disable iff (reset)
      !(step && item.req_type == REQ_VBLANK) |=> $stable(frame_ff))
      else $error("animation frame moved without a vblank");

   a_fire_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      fired |-> item.req_type == REQ_TICK)
      else $error("timer fired on a non-tick event");

endmodule

### sv/video_timer_irq_controller.sv
// video timer / interrupt controller, top level
// a request is held in the input register, then the core result is registered for rsp_tdata
// throughput: one request per cycle; input stalls only while a response waits with
//   rsp_tready low and the input register already holds the following request
// reset: synchronous, clears config to zero, counter/divider/frame to zero,
// arms vblank and timer, leaves only the reset interrupt pending
module video_timer_irq_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // iack_level, ack_mask, load_value
   input  logic [2:0]  req_tuser,  // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // irq_level, anim_frame, timer_fired, timer_count
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);
   import vtic_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;
   logic         advance;
   logic         req_take;
   cfg_type      cfg;
   rsp_item_type core_result;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_item_in.req_type   = req_tuser;
      in_item_in.iack_level = req_tdata[2:0];
      in_item_in.ack_mask   = req_tdata[5:3];
      in_item_in.load_value = req_tdata[37:6];
      in_valid_in  = req_take || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
      rsp_item_in  = advance ? core_result : rsp_item_ff;
   end

   vtic_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   vtic_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) in_item_ff <= in_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_item_ff.timer_count, rsp_item_ff.timer_fired,
                        rsp_item_ff.anim_frame, rsp_item_ff.irq_level};

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("input stalled with an empty response register");

   a_advance_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed transaction did not reach the response register");

   a_held_input_stays: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("stalled transaction lost from input register");

endmodule

### sim/vtic_status_checker.sv
// checker for the video timer / interrupt controller: watches the request, csr and
// response channels, predicts each response status and compares it field by field
// depends on vtic_pkg
`timescale 1ns / 1ps

module vtic_status_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,  // iack_level, ack_mask, load_value
   input  logic [2:0]  req_tuser,  // req_type
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,  // irq_level, anim_frame, timer_fired, timer_count
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata,
   output int          outstanding,
   output int          fail_count
);
   import vtic_pkg::*;

   cfg_type      cfg;
   logic [31:0]  counter;
   logic [7:0]   anim_div;
   logic [2:0]   frame;
   logic [2:0]   armed;
   logic [2:0]   pending;
   rsp_item_type expected_status[$];
   int           errors = 0;

   assign fail_count = errors;

   // applies one request to the predicted state and returns the status it reports
   function automatic rsp_item_type next_status(req_item_type r);
      rsp_item_type s;
      s = '0;
      case (r.req_type)
         REQ_TICK: begin
            if (counter != 32'd0) begin
               counter = counter - 32'd1;
               if (counter == 32'd0) begin
                  if (cfg.reload_when_zero) counter = cfg.timer_reload;
                  if (armed[FLAG_TIMER] && cfg.timer_irq_enable) begin
                     armed[FLAG_TIMER]   = 1'b0;
                     pending[FLAG_TIMER] = 1'b1;
                     s.timer_fired       = 1'b1;
                  end
               end
            end
         end
         REQ_VBLANK: begin
            if (armed[FLAG_VBLANK]) begin
               armed[FLAG_VBLANK]   = 1'b0;
               pending[FLAG_VBLANK] = 1'b1;
            end
            if (cfg.reload_at_vblank) counter = cfg.timer_reload;
            if (anim_div == 8'd0) begin
               anim_div = cfg.anim_reload;
               frame    = frame + 3'd1;
            end else begin
               anim_div = anim_div - 8'd1;
            end
         end
         REQ_IACK: begin
            if (r.iack_level == {1'b0, IRQ_VBLANK}) pending[FLAG_VBLANK] = 1'b0;
            else if (r.iack_level == {1'b0, IRQ_TIMER}) pending[FLAG_TIMER] = 1'b0;
            else if (r.iack_level == {1'b0, IRQ_RESET}) pending[FLAG_RESET] = 1'b0;
         end
         REQ_ACK_WR: armed = armed | r.ack_mask;
         REQ_LOAD:   counter = r.load_value;
         default: ;
      endcase
      if (pending[FLAG_RESET]) s.irq_level = IRQ_RESET;
      else if (pending[FLAG_TIMER]) s.irq_level = IRQ_TIMER;
      else if (pending[FLAG_VBLANK]) s.irq_level = IRQ_VBLANK;
      else s.irq_level = IRQ_NONE;
      s.anim_frame  = frame;
      s.timer_count = counter;
      return s;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] exp_val,
                                input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type exp_s;
      req_item_type r;
      if (reset) begin
         cfg      = '0;
         counter  = '0;
         anim_div = '0;
         frame    = '0;
         armed    = ARMED_RESET_VALUE;
         pending  = PENDING_RESET_VALUE;
         expected_status.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_addr)
               CSR_TIMER_RELOAD:     cfg.timer_reload     = csr_wdata;
               CSR_RELOAD_WHEN_ZERO: cfg.reload_when_zero = csr_wdata[0];
               CSR_RELOAD_AT_VBLANK: cfg.reload_at_vblank = csr_wdata[0];
               CSR_TIMER_IRQ_ENABLE: cfg.timer_irq_enable = csr_wdata[0];
               CSR_ANIM_RELOAD:      cfg.anim_reload      = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_status.size() == 0) begin
               $error("response transaction with no request outstanding: %h", rsp_tdata);
               errors++;
            end else begin
               exp_s = expected_status.pop_front();
               compare_field("irq_level", 32'(exp_s.irq_level), 32'(rsp_tdata[1:0]));
               compare_field("anim_frame", 32'(exp_s.anim_frame), 32'(rsp_tdata[4:2]));
               compare_field("timer_fired", 32'(exp_s.timer_fired), 32'(rsp_tdata[5]));
               compare_field("timer_count", exp_s.timer_count, rsp_tdata[37:6]);
            end
         end
         if (req_tvalid && req_tready) begin
            r.req_type   = req_tuser;
            r.iack_level = req_tdata[2:0];
            r.ack_mask   = req_tdata[5:3];
            r.load_value = req_tdata[37:6];
            expected_status.push_back(next_status(r));
         end
      end
      outstanding <= expected_status.size();
   end

endmodule

### sim/tb_video_timer_irq_controller.sv
// testbench top for the video timer / interrupt controller: reset, csr setup,
// directed and random request streams with idling phases; uses vtic_status_checker
// depends on vtic_pkg, video_timer_irq_controller and vtic_status_checker
`timescale 1ns / 1ps

module tb_video_timer_irq_controller;
   import vtic_pkg::*;

   localparam int CYCLE_LIMIT     = 300000;
   localparam int ITEMS_PER_PHASE = 290;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int NUM_PHASES      = 6;
   // acknowledge levels that no interrupt source uses
   localparam logic [2:0] IACK_UNUSED_LO = 3'd4;
   localparam logic [2:0] IACK_UNUSED_HI = 3'd7;
   localparam logic [2:0] MASK_ALL       = 3'b111;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [39:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tready = 1'b0;
   logic        csr_valid  = 1'b0;
   logic [2:0]  csr_addr   = '0;
   logic [31:0] csr_wdata  = '0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [39:0] rsp_tdata;
   logic        csr_ready;

   logic hold_off    = 1'b0;
   int   stall_pct   = 0;
   int   idle_pct    = 0;
   int   cycle_count = 0;
   int   outstanding;
   int   fail_count;

   always #5 clock = ~clock;

   video_timer_irq_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   vtic_status_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   // response side back-pressure
   always @(posedge clock) begin
      if (reset || hold_off) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic req_item_type make_req(logic [2:0] kind, logic [2:0] lvl,
                                             logic [2:0] mask, logic [31:0] load);
      req_item_type r;
      r.req_type   = kind;
      r.iack_level = lvl;
      r.ack_mask   = mask;
      r.load_value = load;
      return r;
   endfunction

   // mostly short counts so the timer keeps reaching zero
   function automatic req_item_type pick_req();
      req_item_type r;
      int           sel;
      int           ld;
      r.iack_level = 3'($urandom_range(7));
      r.ack_mask   = 3'($urandom_range(7));
      r.load_value = $urandom();
      sel = $urandom_range(99);
      if (sel < 40) r.req_type = REQ_TICK;
      else if (sel < 55) r.req_type = REQ_VBLANK;
      else if (sel < 68) begin
         r.req_type = REQ_IACK;
         if ($urandom_range(99) < 80)
            r.iack_level = 3'($urandom_range(IRQ_VBLANK, IRQ_RESET));
      end else if (sel < 78) r.req_type = REQ_ACK_WR;
      else if (sel < 95) begin
         r.req_type = REQ_LOAD;
         ld = $urandom_range(99);
         if (ld < 60) r.load_value = $urandom_range(0, 6);
         else if (ld < 70) r.load_value = '1;
         else if (ld < 80) r.load_value = $urandom_range(1, 40);
      end else r.req_type = 3'($urandom_range(REQ_LOAD + 1, 7));
      return r;
   endfunction

   function automatic cfg_type pick_cfg();
      cfg_type c;
      int      sel;
      sel = $urandom_range(99);
      if (sel < 70) c.timer_reload = $urandom_range(1, 8);
      else if (sel < 85) c.timer_reload = $urandom();
      else c.timer_reload = '0;
      c.reload_when_zero = 1'($urandom_range(1));
      c.reload_at_vblank = 1'($urandom_range(1));
      c.timer_irq_enable = 1'($urandom_range(1));
      c.anim_reload      = ($urandom_range(99) < 70) ? 8'($urandom_range(0, 3))
                                                     : 8'($urandom_range(255));
      return c;
   endfunction

   task automatic send_req(input req_item_type r);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.req_type;
      req_tdata  <= {2'b00, r.load_value, r.ack_mask, r.iack_level};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic write_cfg(input cfg_type c);
      write_reg(CSR_TIMER_RELOAD, c.timer_reload);
      write_reg(CSR_RELOAD_WHEN_ZERO, {31'd0, c.reload_when_zero});
      write_reg(CSR_RELOAD_AT_VBLANK, {31'd0, c.reload_at_vblank});
      write_reg(CSR_TIMER_IRQ_ENABLE, {31'd0, c.timer_irq_enable});
      write_reg(CSR_ANIM_RELOAD, {24'd0, c.anim_reload});
      csr_valid <= 1'b0;
   endtask

   // wait until every response has come back, then let the pipeline settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_random(input int n);
      repeat (n) send_req(pick_req());
   endtask

   initial begin
      cfg_type c;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default config: tick on a zero counter, unused kinds, stray acknowledges, then a reset acknowledge and a vblank
      send_req(make_req(REQ_TICK, '0, '0, '0));
      for (int k = REQ_LOAD + 1; k < 8; k++)
         send_req(make_req(k[2:0], 3'($urandom_range(7)), 3'($urandom_range(7)),
                           $urandom()));
      send_req(make_req(REQ_IACK, {1'b0, IRQ_NONE}, '0, '0));
      send_req(make_req(REQ_IACK, IACK_UNUSED_LO, '0, '0));
      send_req(make_req(REQ_IACK, IACK_UNUSED_HI, '0, '0));
      send_req(make_req(REQ_IACK, {1'b0, IRQ_RESET}, '0, '0));
      send_req(make_req(REQ_VBLANK, '0, '0, '0));
      drain();

      c = '{timer_reload: 32'd3, reload_when_zero: 1'b1, reload_at_vblank: 1'b1,
            timer_irq_enable: 1'b1, anim_reload: 8'd2};
      write_cfg(c);
      send_req(make_req(REQ_LOAD, '0, '0, 32'd2));
      // fires on reaching zero, then stays quiet until the timer is re-armed
      repeat (5) send_req(make_req(REQ_TICK, '0, '0, '0));
      send_req(make_req(REQ_ACK_WR, '0, 3'b1 << FLAG_TIMER, '0));
      send_req(make_req(REQ_IACK, {1'b0, IRQ_TIMER}, '0, '0));
      send_req(make_req(REQ_VBLANK, '0, '0, '0));
      send_req(make_req(REQ_VBLANK, '0, '0, '0));
      send_req(make_req(REQ_IACK, {1'b0, IRQ_VBLANK}, '0, '0));
      send_req(make_req(REQ_ACK_WR, '0, MASK_ALL, '0));
      send_req(make_req(REQ_LOAD, MASK_ALL, MASK_ALL, '1));
      send_req(make_req(REQ_TICK, MASK_ALL, MASK_ALL, '1));
      send_req(make_req(REQ_LOAD, '0, '0, '0));
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: c = '{timer_reload: '1, reload_when_zero: 1'b1, reload_at_vblank: 1'b1,
                     timer_irq_enable: 1'b1, anim_reload: '1};
            1: c = '0;
            5: c = '{timer_reload: 32'd1, reload_when_zero: 1'b1, reload_at_vblank: 1'b0,
                     timer_irq_enable: 1'b1, anim_reload: '1};
            default: c = pick_cfg();
         endcase
         write_cfg(c);
         idle_pct = (p == 1) ? 78 : (p == 3 || p == 5) ? 35 : 0;
         stall_pct <= (p == 2) ? 78 : (p == 3 || p == 5) ? 35 : 0;
         if (p == 4) begin
            // long receiver hold-off while requests keep coming
            fork
               begin
                  hold_off <= 1'b1;
                  repeat (HOLD_OFF_CYCLES) @(posedge clock);
                  hold_off <= 1'b0;
               end
               run_random(ITEMS_PER_PHASE);
            join
         end else begin
            run_random(ITEMS_PER_PHASE);
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### filelist.f
sv/vtic_pkg.sv
sv/vtic_csr.sv
sv/vtic_core.sv
sv/video_timer_irq_controller.sv
sim/vtic_status_checker.sv
sim/tb_video_timer_irq_controller.sv
